/* sv/mpbf_pkg.sv */
// Package for the multi-pipe byte FIFO table: sizes, operation and status codes,
// and the per-entry bookkeeping record. It depends on nothing else.
`default_nettype none

package mpbf_pkg;

	localparam int NUM_PIPES   = 8;
	localparam int BUF_DEPTH   = 256;
	localparam int IDX_W       = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
	localparam int PTR_W       = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int FILL_W      = $clog2(BUF_DEPTH + 1);
	localparam int STORE_DEPTH = NUM_PIPES * BUF_DEPTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = 16;
	localparam int ID_W        = 16;
	localparam int OPC_W       = 2;
	localparam int ST_W        = 3;
	localparam int BYTE_W      = 8;

	localparam logic [OPC_W-1:0] OP_OPEN  = 2'd0;
	localparam logic [OPC_W-1:0] OP_CLOSE = 2'd1;
	localparam logic [OPC_W-1:0] OP_WRITE = 2'd2;
	localparam logic [OPC_W-1:0] OP_READ  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK     = 3'd0;
	localparam logic [ST_W-1:0] ST_NOPIPE = 3'd1;
	localparam logic [ST_W-1:0] ST_TFULL  = 3'd2;
	localparam logic [ST_W-1:0] ST_PFULL  = 3'd3;
	localparam logic [ST_W-1:0] ST_PEMPTY = 3'd4;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef struct packed {
		logic [CNT_W-1:0]  open_count;
		logic [PTR_W-1:0]  write_pointer;
		logic [PTR_W-1:0]  read_pointer;
		logic [FILL_W-1:0] fill_count;
	} meta_t;

endpackage

`default_nettype wire

/* sv/multi_pipe_byte_fifo_table.sv */
// Top level of the multi-pipe byte FIFO table: entry lookup, bookkeeping memory,
// byte store memory and the stream ports. It depends on mpbf_pkg.
//
// Each transfer on the s_ side carries one command: open, close, write one byte
// or read one byte of the pipe named by pipe_id. Every command gives exactly one
// transfer on the m_ side with a status and, for a successful read, the byte.
// Identifiers and valid flags sit in registers and are compared in parallel.
// Pointers, fill and open counts live in a small memory, the bytes in a second
// memory; both have a registered read port.
// A command is looked up and its bookkeeping read in the cycle it is taken, is
// executed in the next cycle, and its result passes the status register of the
// second stage into the output register once that register is free. A new
// command is taken only once the previous one has left both execution stages,
// so commands never share those stages; each command reads and writes back one entry.
// A stalled receiver holds the result in the output register; one more command
// can then run up to the last stage and waits there.
// Reset clears the valid flags and the control state at once; the table starts
// empty and no clearing pass is needed.
`default_nettype none

module multi_pipe_byte_fifo_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // opcode[1:0], pipe_id[17:2], data_byte[25:18]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // status[2:0], read_byte[10:3]
);

	logic [mpbf_pkg::OPC_W-1:0]  in_opcode;
	logic [mpbf_pkg::ID_W-1:0]   in_pipe_id;
	logic [mpbf_pkg::BYTE_W-1:0] in_data_byte;
	logic                        accept;

	logic [mpbf_pkg::NUM_PIPES-1:0] entry_valid_q;
	logic [mpbf_pkg::ID_W-1:0]      entry_ident_q [mpbf_pkg::NUM_PIPES];

	logic                       hit;
	logic                       free_ok;
	logic [mpbf_pkg::IDX_W-1:0] hit_idx;
	logic [mpbf_pkg::IDX_W-1:0] free_idx;

	mpbf_pkg::meta_t meta_mem [mpbf_pkg::NUM_PIPES];
	mpbf_pkg::meta_t meta_rd_q;
	mpbf_pkg::meta_t meta_nxt;
	logic            meta_we;

	logic [mpbf_pkg::BYTE_W-1:0] byte_store [mpbf_pkg::STORE_DEPTH];
	logic [mpbf_pkg::BYTE_W-1:0] byte_rd_q;
	logic                        byte_we;
	logic                        byte_re;
	logic [mpbf_pkg::ADDR_W-1:0] byte_addr;

	logic                        valid_s1;
	logic [mpbf_pkg::OPC_W-1:0]  opcode_s1;
	logic [mpbf_pkg::ID_W-1:0]   pipe_id_s1;
	logic [mpbf_pkg::BYTE_W-1:0] data_s1;
	logic                        hit_s1;
	logic                        free_ok_s1;
	logic [mpbf_pkg::IDX_W-1:0]  idx_s1;

	logic                      valid_s2;
	logic [mpbf_pkg::ST_W-1:0] status_s2;
	logic                      rd_ok_s2;

	logic [mpbf_pkg::ST_W-1:0] status_nxt;
	logic                      set_valid;
	logic                      clr_valid;
	logic                      move_s2;

	logic        out_valid_q;
	logic [15:0] out_data_q;

	assign in_opcode    = s_tdata[1:0];
	assign in_pipe_id   = s_tdata[17:2];
	assign in_data_byte = s_tdata[25:18];

	assign s_tready = !valid_s1 && !valid_s2;
	assign accept   = s_tvalid && s_tready;
	assign move_s2  = valid_s2 && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_comb begin
		hit      = 1'b0;
		free_ok  = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int k = mpbf_pkg::NUM_PIPES - 1; k >= 0; k--) begin
			if (entry_valid_q[k] && entry_ident_q[k] == in_pipe_id) begin
				hit     = 1'b1;
				hit_idx = mpbf_pkg::IDX_W'(k);
			end
			if (!entry_valid_q[k]) begin
				free_ok  = 1'b1;
				free_idx = mpbf_pkg::IDX_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1  <= in_opcode;
			pipe_id_s1 <= in_pipe_id;
			data_s1    <= in_data_byte;
			hit_s1     <= hit;
			free_ok_s1 <= free_ok;
			idx_s1     <= hit ? hit_idx : free_idx;
			meta_rd_q  <= meta_mem[hit ? hit_idx : free_idx];
		end
	end

	always_comb begin
		meta_nxt   = meta_rd_q;
		meta_we    = 1'b0;
		byte_we    = 1'b0;
		byte_re    = 1'b0;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		status_nxt = mpbf_pkg::ST_OK;
		byte_addr  = mpbf_pkg::ADDR_W'(idx_s1) * mpbf_pkg::ADDR_W'(mpbf_pkg::BUF_DEPTH)
			+ mpbf_pkg::ADDR_W'(meta_rd_q.write_pointer);
		if (opcode_s1 == mpbf_pkg::OP_READ) begin
			byte_addr = mpbf_pkg::ADDR_W'(idx_s1) * mpbf_pkg::ADDR_W'(mpbf_pkg::BUF_DEPTH)
				+ mpbf_pkg::ADDR_W'(meta_rd_q.read_pointer);
		end
		if (opcode_s1 == mpbf_pkg::OP_OPEN) begin
			if (hit_s1) begin
				meta_we = 1'b1;
				if (meta_rd_q.open_count != mpbf_pkg::CNT_MAX) begin
					meta_nxt.open_count = meta_rd_q.open_count + 1'b1;
				end
			end else if (free_ok_s1) begin
				meta_we   = 1'b1;
				set_valid = 1'b1;
				meta_nxt  = '{open_count: mpbf_pkg::CNT_W'(1), write_pointer: '0,
					read_pointer: '0, fill_count: '0};
			end else begin
				status_nxt = mpbf_pkg::ST_TFULL;
			end
		end else if (!hit_s1) begin
			status_nxt = mpbf_pkg::ST_NOPIPE;
		end else begin
			case (opcode_s1)
				mpbf_pkg::OP_CLOSE: begin
					meta_we = 1'b1;
					if (meta_rd_q.open_count <= mpbf_pkg::CNT_W'(1)) begin
						meta_nxt.open_count = '0;
						clr_valid           = 1'b1;
					end else begin
						meta_nxt.open_count = meta_rd_q.open_count - 1'b1;
					end
				end
				mpbf_pkg::OP_WRITE: begin
					if (meta_rd_q.fill_count >= mpbf_pkg::FILL_W'(mpbf_pkg::BUF_DEPTH)) begin
						status_nxt = mpbf_pkg::ST_PFULL;
					end else begin
						meta_we  = 1'b1;
						byte_we  = 1'b1;
						meta_nxt.fill_count = meta_rd_q.fill_count + 1'b1;
						meta_nxt.write_pointer = (meta_rd_q.write_pointer
							== mpbf_pkg::PTR_W'(mpbf_pkg::BUF_DEPTH - 1))
							? '0 : meta_rd_q.write_pointer + 1'b1;
					end
				end
				mpbf_pkg::OP_READ: begin
					if (meta_rd_q.fill_count == '0) begin
						status_nxt = mpbf_pkg::ST_PEMPTY;
					end else begin
						meta_we  = 1'b1;
						byte_re  = 1'b1;
						meta_nxt.fill_count = meta_rd_q.fill_count - 1'b1;
						meta_nxt.read_pointer = (meta_rd_q.read_pointer
							== mpbf_pkg::PTR_W'(mpbf_pkg::BUF_DEPTH - 1))
							? '0 : meta_rd_q.read_pointer + 1'b1;
					end
				end
				default: begin
					status_nxt = mpbf_pkg::ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && meta_we) begin
			meta_mem[idx_s1] <= meta_nxt;
		end
		if (valid_s1 && byte_we) begin
			byte_store[byte_addr] <= data_s1;
		end
		if (valid_s1 && byte_re) begin
			byte_rd_q <= byte_store[byte_addr];
		end
		if (valid_s1 && set_valid) begin
			entry_ident_q[idx_s1] <= pipe_id_s1;
		end
		if (valid_s1) begin
			status_s2 <= status_nxt;
			rd_ok_s2  <= byte_re;
		end
		if (move_s2) begin
			out_data_q <= {5'd0, rd_ok_s2 ? byte_rd_q : 8'd0, status_s2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			valid_s2      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (valid_s1 && set_valid) begin
				entry_valid_q[idx_s1] <= 1'b1;
			end else if (valid_s1 && clr_valid) begin
				entry_valid_q[idx_s1] <= 1'b0;
			end
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (move_s2) begin
				valid_s2 <= 1'b0;
			end
			if (move_s2) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* tb/sv/multi_pipe_byte_fifo_table_test.sv */
// Self-checking testbench for the multi-pipe byte FIFO table: a queue-fed stream driver,
// a result monitor and a command-level predictor of the pipe table. It depends on
// mpbf_pkg and multi_pipe_byte_fifo_table.
`default_nettype none

module multi_pipe_byte_fifo_table_test;
	import mpbf_pkg::*;

	localparam int PLAN        = 0;
	localparam int LIVE        = 1;
	localparam int HOLD_SPAN   = 300;
	localparam int STALL_LIMIT = 2000;
	localparam int RAND_ITEMS  = 1100;

	typedef enum logic [1:0] {SEND_CMD, SEND_FENCE, SEND_HOLD} step_kind_t;

	typedef struct packed {
		logic [OPC_W-1:0]  opcode;
		logic [ID_W-1:0]   pipe_id;
		logic [BYTE_W-1:0] data;
	} cmd_t;

	typedef struct packed {
		step_kind_t kind;
		logic       quiet;
		cmd_t       cmd;
	} step_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [BYTE_W-1:0] rbyte;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	multi_pipe_byte_fifo_table u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Two copies of the table: one tracks the plan while stimulus is built,
	// the other follows the transfers the block actually accepts.
	logic              pipe_valid [2][NUM_PIPES];
	logic [ID_W-1:0]   pipe_ident [2][NUM_PIPES];
	logic [CNT_W-1:0]  pipe_opens [2][NUM_PIPES];
	logic [PTR_W-1:0]  wr_ptr     [2][NUM_PIPES];
	logic [PTR_W-1:0]  rd_ptr     [2][NUM_PIPES];
	logic [FILL_W-1:0] fill_level [2][NUM_PIPES];
	logic [BYTE_W-1:0] pipe_bytes [2][NUM_PIPES][BUF_DEPTH];

	step_t  pending_steps[$];
	reply_t due_replies[$];

	logic quiet_mode = 1'b0;
	logic gen_quiet = 1'b0;
	logic fence_wait = 1'b0;
	logic hold_req = 1'b0;
	logic in_taken = 1'b0;
	logic out_taken = 1'b0;
	int   tx_gap = 0;
	int   rx_gap = 0;
	int   hold_left = 0;
	int   mismatches = 0;
	int   cmds_taken = 0;
	int   replies_checked = 0;
	int   planned = 0;
	int   status_tally [8];

	function automatic reply_t table_step(input int c, input cmd_t cmd);
		int     hit;
		int     slot;
		reply_t r;
		r.status = ST_OK;
		r.rbyte = '0;
		hit = NUM_PIPES;
		slot = NUM_PIPES;
		for (int k = NUM_PIPES - 1; k >= 0; k--) begin
			if (pipe_valid[c][k] && pipe_ident[c][k] == cmd.pipe_id) hit = k;
			if (!pipe_valid[c][k]) slot = k;
		end
		if (cmd.opcode == OP_OPEN) begin
			if (hit < NUM_PIPES) begin
				if (pipe_opens[c][hit] != CNT_MAX) pipe_opens[c][hit]++;
			end else if (slot < NUM_PIPES) begin
				pipe_valid[c][slot] = 1'b1;
				pipe_ident[c][slot] = cmd.pipe_id;
				pipe_opens[c][slot] = CNT_W'(1);
				wr_ptr[c][slot] = '0;
				rd_ptr[c][slot] = '0;
				fill_level[c][slot] = '0;
			end else begin
				r.status = ST_TFULL;
			end
		end else if (hit == NUM_PIPES) begin
			r.status = ST_NOPIPE;
		end else if (cmd.opcode == OP_CLOSE) begin
			if (pipe_opens[c][hit] <= 1) begin
				pipe_opens[c][hit] = '0;
				pipe_valid[c][hit] = 1'b0;
			end else begin
				pipe_opens[c][hit]--;
			end
		end else if (cmd.opcode == OP_WRITE) begin
			if (fill_level[c][hit] >= BUF_DEPTH) begin
				r.status = ST_PFULL;
			end else begin
				pipe_bytes[c][hit][wr_ptr[c][hit]] = cmd.data;
				wr_ptr[c][hit] = PTR_W'((int'(wr_ptr[c][hit]) + 1) % BUF_DEPTH);
				fill_level[c][hit]++;
			end
		end else begin
			if (fill_level[c][hit] == 0) begin
				r.status = ST_PEMPTY;
			end else begin
				r.rbyte = pipe_bytes[c][hit][rd_ptr[c][hit]];
				rd_ptr[c][hit] = PTR_W'((int'(rd_ptr[c][hit]) + 1) % BUF_DEPTH);
				fill_level[c][hit]--;
			end
		end
		return r;
	endfunction

	task automatic add_cmd(input logic [OPC_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [BYTE_W-1:0] data);
		step_t st;
		st.kind = SEND_CMD;
		st.quiet = gen_quiet;
		st.cmd.opcode = op;
		st.cmd.pipe_id = id;
		st.cmd.data = data;
		pending_steps.push_back(st);
		void'(table_step(PLAN, st.cmd));
		planned++;
	endtask

	task automatic add_marker(input step_kind_t kind);
		step_t st;
		st = '0;
		st.kind = kind;
		st.quiet = gen_quiet;
		pending_steps.push_back(st);
	endtask

	task automatic close_all();
		for (int k = 0; k < NUM_PIPES; k++) begin
			while (pipe_valid[PLAN][k]) add_cmd(OP_CLOSE, pipe_ident[PLAN][k], 8'h00);
		end
	endtask

	initial begin
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		step_t st;
		logic  next_valid;
		if (arst_n && !(s_tvalid && !in_taken)) begin
			next_valid = 1'b0;
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (fence_wait) begin
				if (due_replies.size() == 0) fence_wait = 1'b0;
			end else if (pending_steps.size() > 0) begin
				st = pending_steps.pop_front();
				quiet_mode = st.quiet;
				case (st.kind)
					SEND_FENCE: fence_wait = 1'b1;
					SEND_HOLD: hold_req = 1'b1;
					default: begin
						s_tdata <= {6'd0, st.cmd.data, st.cmd.pipe_id, st.cmd.opcode};
						next_valid = 1'b1;
						tx_gap = st.quiet ? 0 : $urandom_range(0, 14);
					end
				endcase
			end
			s_tvalid <= next_valid;
		end
	end

	always @(negedge clk) begin
		logic rdy;
		if (arst_n) begin
			if (out_taken) rx_gap = quiet_mode ? 0 : $urandom_range(0, 14);
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_SPAN - 1;
				rdy = 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			m_tready <= rdy;
		end
	end

	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		cmd_t   cmd;
		in_taken = arst_n && s_tvalid && s_tready;
		out_taken = arst_n && m_tvalid && m_tready;
		if (out_taken) begin
			got.status = m_tdata[2:0];
			got.rbyte = m_tdata[10:3];
			status_tally[got.status]++;
			if (due_replies.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer, expected none, actual status %0d byte 0x%02h",
					$time, got.status, got.rbyte);
			end else begin
				want = due_replies.pop_front();
				replies_checked++;
				if (got.status != want.status) begin
					mismatches++;
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, got.status);
				end
				if (got.rbyte != want.rbyte) begin
					mismatches++;
					$display("%0t: read byte mismatch, expected 0x%02h, actual 0x%02h",
						$time, want.rbyte, got.rbyte);
				end
			end
		end
		if (in_taken) begin
			cmd.opcode = s_tdata[1:0];
			cmd.pipe_id = s_tdata[17:2];
			cmd.data = s_tdata[25:18];
			due_replies.push_back(table_step(LIVE, cmd));
			cmds_taken++;
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
			else idle++;
		end
		$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		logic [ID_W-1:0] pipe_pool [16];
		logic [ID_W-1:0] id;
		int              n;
		int              kind;
		int              rand_items;
		int              next_fence;
		logic            hold_done;

		for (int c = 0; c < 2; c++) begin
			for (int k = 0; k < NUM_PIPES; k++) begin
				pipe_valid[c][k] = 1'b0;
				pipe_ident[c][k] = '0;
				pipe_opens[c][k] = '0;
				wr_ptr[c][k] = '0;
				rd_ptr[c][k] = '0;
				fill_level[c][k] = '0;
			end
		end
		for (int s = 0; s < 8; s++) status_tally[s] = 0;

		add_cmd(OP_READ, 16'h1234, 8'h00);
		add_cmd(OP_CLOSE, 16'hFFFF, 8'h00);
		add_cmd(OP_WRITE, 16'h0000, 8'hFF);
		add_cmd(OP_OPEN, 16'h0000, 8'h00);
		add_cmd(OP_OPEN, 16'hFFFF, 8'hFF);
		add_cmd(OP_READ, 16'h0000, 8'h00);
		add_cmd(OP_WRITE, 16'h0000, 8'h00);
		add_cmd(OP_WRITE, 16'h0000, 8'hFF);
		add_cmd(OP_WRITE, 16'hFFFF, 8'hA5);
		add_cmd(OP_READ, 16'h0000, 8'h00);
		add_cmd(OP_READ, 16'h0000, 8'h00);
		add_cmd(OP_READ, 16'h0000, 8'h00);
		add_cmd(OP_OPEN, 16'hFFFF, 8'h00);
		add_cmd(OP_CLOSE, 16'hFFFF, 8'h00);
		add_cmd(OP_READ, 16'hFFFF, 8'h00);
		add_cmd(OP_WRITE, 16'hFFFF, 8'h5A);
		add_cmd(OP_CLOSE, 16'hFFFF, 8'h00);
		add_cmd(OP_OPEN, 16'hFFFF, 8'h00);
		add_cmd(OP_READ, 16'hFFFF, 8'h00);
		add_cmd(OP_OPEN, 16'h0001, 8'h00);
		add_cmd(OP_OPEN, 16'h8000, 8'h00);
		add_cmd(OP_OPEN, 16'h00FF, 8'h00);
		add_cmd(OP_OPEN, 16'hFF00, 8'h00);
		add_cmd(OP_OPEN, 16'h5555, 8'h00);
		add_cmd(OP_OPEN, 16'hAAAA, 8'h00);
		add_cmd(OP_OPEN, 16'h1357, 8'h00);
		add_cmd(OP_CLOSE, 16'h0000, 8'h00);
		add_cmd(OP_OPEN, 16'h1357, 8'h00);
		add_marker(SEND_FENCE);

		// Fill one pipe past its depth, then drain it past empty; the pointers wrap.
		close_all();
		id = ID_W'($urandom_range(0, 65535));
		add_cmd(OP_OPEN, id, 8'h00);
		repeat (BUF_DEPTH + 2) add_cmd(OP_WRITE, id, BYTE_W'($urandom_range(0, 255)));
		repeat (BUF_DEPTH + 2) add_cmd(OP_READ, id, BYTE_W'($urandom_range(0, 255)));
		repeat (5) add_cmd(OP_WRITE, id, BYTE_W'($urandom_range(0, 255)));
		repeat (5) add_cmd(OP_READ, id, BYTE_W'($urandom_range(0, 255)));
		add_cmd(OP_CLOSE, id, 8'h00);
		add_marker(SEND_FENCE);

		pipe_pool[0] = 16'h0000;
		pipe_pool[1] = 16'hFFFF;
		for (int p = 2; p < 16; p++) pipe_pool[p] = ID_W'($urandom_range(1, 65534));
		rand_items = 0;
		next_fence = 400;
		hold_done = 1'b0;
		while (rand_items < RAND_ITEMS) begin
			n = planned;
			gen_quiet = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			id = pipe_pool[$urandom_range(0, 15)];
			if (kind <= 4) begin
				add_cmd(OP_OPEN, id, BYTE_W'($urandom_range(0, 255)));
				repeat ($urandom_range(1, 24))
					add_cmd(OP_WRITE, id, BYTE_W'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 26))
					add_cmd(OP_READ, id, BYTE_W'($urandom_range(0, 255)));
				if ($urandom_range(0, 1)) add_cmd(OP_CLOSE, id, BYTE_W'($urandom_range(0, 255)));
			end else if (kind <= 6) begin
				repeat ($urandom_range(1, 10))
					add_cmd(OPC_W'($urandom_range(0, 3)), pipe_pool[$urandom_range(0, 15)],
						BYTE_W'($urandom_range(0, 255)));
			end else if (kind == 7) begin
				repeat ($urandom_range(1, 5))
					add_cmd(OPC_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, 65535)),
						BYTE_W'($urandom_range(0, 255)));
			end else if (kind == 8) begin
				repeat ($urandom_range(1, 6))
					add_cmd(OP_CLOSE, pipe_pool[$urandom_range(0, 15)],
						BYTE_W'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 10))
					add_cmd(OP_OPEN, $urandom_range(0, 1) ? pipe_pool[$urandom_range(0, 15)] :
						16'($urandom_range(0, 65535)), BYTE_W'($urandom_range(0, 255)));
			end
			rand_items += planned - n;
			if (!hold_done && rand_items >= 300) begin
				hold_done = 1'b1;
				add_marker(SEND_HOLD);
			end
			if (rand_items >= next_fence) begin
				next_fence += 350;
				add_marker(SEND_FENCE);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_steps.size() != 0 || s_tvalid) @(posedge clk);
		while (due_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("run covered %0d commands and %0d checked results, with pipes filled and drained",
			cmds_taken, replies_checked);
		$display("results seen: ok %0d, no pipe %0d, table full %0d, pipe full %0d, empty %0d",
			status_tally[ST_OK], status_tally[ST_NOPIPE], status_tally[ST_TFULL],
			status_tally[ST_PFULL], status_tally[ST_PEMPTY]);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* multi_pipe_byte_fifo_table.f */
sv/mpbf_pkg.sv
sv/multi_pipe_byte_fifo_table.sv
tb/sv/multi_pipe_byte_fifo_table_test.sv
